// ===== src/vtp_pkg.sv =====
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int SUM_W     = 66;
  localparam int MAG_W     = 65;
  localparam int Q_W       = 33;
  localparam int DIV_LAT   = 34;

  localparam logic OP_POINT = 1'b0;
  localparam logic OP_DIR   = 1'b1;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               op;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               w_zero;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic valid;
    logic point;
  } meta_t;

  typedef logic [NUM_REGS-1:0][63:0] matrix_t;

  // Pick matrix element M[row][col] out of the packed register file.
  function automatic logic signed [31:0] elem(matrix_t m, logic [1:0] row, logic [1:0] col);
    logic [63:0] r;
    r = m[{row, col[1]}];
    return col[0] ? r[63:32] : r[31:0];
  endfunction

endpackage

// ===== src/vertex_transform_perspective_core.sv =====
`timescale 1ns / 1ps
// Both modes pass through the same pipeline, divider included, to the result strobe.
// Throughput: one transaction per cycle; busy stays low, so start may be held every cycle.
// Most of the latency is the restoring divider, one quotient bit per stage.
// Reset (rst, synchronous): clears all pipeline valid bits and loads the identity matrix.
// The receiver cannot stall; each result appears for one cycle on result_valid.
module vertex_transform_perspective_core
  import vtp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  item,
  output logic                 result_valid,
  output out_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef struct packed {
    meta_t       meta;
    logic [2:0]  neg;
    logic [95:0] dir_val;
    logic        dir_sat;
    logic [31:0] w;
    logic        w_sat;
    logic        w_zero;
    logic        w_sign;
  } ctl_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } satv_t;

  // Narrow a Q33.16 magnitude to Q16.16 and clamp with sign applied.
  function automatic satv_t sat_trunc(logic neg, logic [48:0] m);
    satv_t r;
    r.sat = neg ? (m > 49'(Q_MIN)) : (m > 49'(Q_MAX));
    if (r.sat) begin
      r.val = neg ? Q_MIN : Q_MAX;
    end else begin
      r.val = neg ? 32'(-m[31:0]) : m[31:0];
    end
    return r;
  endfunction

  matrix_t                 mat;
  logic                    accept;
  meta_t                   meta_a;
  logic signed [31:0]      xa, ya, za;
  meta_t                   meta_c;
  logic signed [SUM_W-1:0] sums [4];
  meta_t                   meta_d;
  logic [MAG_W-1:0]        mag_d [4];
  logic [3:0]              neg_d;
  ctl_t                    ctl_e;
  logic [MAG_W-1:0]        mag_e [3];
  logic [31:0]             wmag_e;
  ctl_t                    dly [DIV_LAT];
  logic [Q_W-1:0]          quo [3];
  logic                    ovf [3];
  satv_t                   dir_r [3];
  satv_t                   w_r;
  ctl_t                    ctl_f;
  logic [31:0]             qval [3];
  logic [2:0]              qsat;

  // Never stall: the pipeline advances every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Matrix registers; drop writes beyond the last index.
  always_ff @(posedge clk) begin
    if (rst) begin
      mat[0] <= 64'h0000_0000_0001_0000;
      mat[1] <= 64'h0;
      mat[2] <= 64'h0001_0000_0000_0000;
      mat[3] <= 64'h0;
      mat[4] <= 64'h0;
      mat[5] <= 64'h0000_0000_0001_0000;
      mat[6] <= 64'h0;
      mat[7] <= 64'h0001_0000_0000_0000;
    end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      mat[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Input register: capture the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_a <= '0;
    end else begin
      meta_a.valid <= accept;
      meta_a.point <= item.op == OP_POINT;
    end
  end

  always_ff @(posedge clk) begin
    xa <= item.in_x;
    ya <= item.in_y;
    za <= item.in_z;
  end

  vtp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .meta_in  (meta_a),
    .vx       (xa),
    .vy       (ya),
    .vz       (za),
    .mat      (mat),
    .meta_out (meta_c),
    .sums     (sums)
  );

  // Sign/magnitude split of the four column sums.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      neg_d[c] <= sums[c][SUM_W-1];
      mag_d[c] <= sums[c][SUM_W-1] ? MAG_W'(-sums[c]) : MAG_W'(sums[c]);
    end
  end

  // Truncate and clamp: w, the direction-mode results, and the divisor magnitude.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dir_r[c] = sat_trunc(neg_d[c], mag_d[c][MAG_W-1:16]);
    end
    w_r = sat_trunc(neg_d[3], mag_d[3][MAG_W-1:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_d <= '0;
    end else begin
      meta_d <= meta_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_e.meta <= '0;
    end else begin
      ctl_e.meta <= meta_d;
    end
    ctl_e.neg     <= neg_d[2:0];
    ctl_e.dir_val <= {dir_r[2].val, dir_r[1].val, dir_r[0].val};
    ctl_e.dir_sat <= dir_r[0].sat | dir_r[1].sat | dir_r[2].sat;
    ctl_e.w       <= w_r.val;
    ctl_e.w_sat   <= w_r.sat;
    ctl_e.w_zero  <= mag_d[3][MAG_W-1:16] == '0;
    ctl_e.w_sign  <= w_r.val[31];
    wmag_e        <= w_r.val[31] ? 32'(-w_r.val) : w_r.val;
    for (int c = 0; c < 3; c++) begin
      mag_e[c] <= mag_d[c];
    end
  end

  // Divide each of x, y, z by |w|; hold the rest of the transaction alongside.
  for (genvar g = 0; g < 3; g++) begin : g_div
    vtp_div u_div (
      .clk  (clk),
      .mag  (mag_e[g]),
      .wmag (wmag_e),
      .quo  (quo[g]),
      .ovf  (ovf[g])
    );
  end

  always_ff @(posedge clk) begin
    dly[0] <= ctl_e;
    for (int i = 1; i < DIV_LAT; i++) begin
      dly[i] <= dly[i-1];
    end
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dly[i].meta <= '0;
      end
    end
  end

  assign ctl_f = dly[DIV_LAT-1];

  // Apply quotient sign and clamp.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic n;
      n       = ctl_f.neg[c] != ctl_f.w_sign;
      qsat[c] = ovf[c] | quo[c][Q_W-1]
              | (n ? (quo[c][31:0] > Q_MIN) : quo[c][31]);
      if (qsat[c]) begin
        qval[c] = n ? Q_MIN : Q_MAX;
      end else begin
        qval[c] = n ? 32'(-quo[c][31:0]) : quo[c][31:0];
      end
    end
  end

  // Output register: one-cycle strobe per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl_f.meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl_f.meta.point) begin
      result.out_x     <= ctl_f.dir_val[31:0];
      result.out_y     <= ctl_f.dir_val[63:32];
      result.out_z     <= ctl_f.dir_val[95:64];
      result.out_w     <= '0;
      result.w_zero    <= 1'b0;
      result.saturated <= ctl_f.dir_sat;
    end else if (ctl_f.w_zero) begin
      result.out_x     <= '0;
      result.out_y     <= '0;
      result.out_z     <= '0;
      result.out_w     <= '0;
      result.w_zero    <= 1'b1;
      result.saturated <= 1'b0;
    end else begin
      result.out_x     <= qval[0];
      result.out_y     <= qval[1];
      result.out_z     <= qval[2];
      result.out_w     <= ctl_f.w;
      result.w_zero    <= 1'b0;
      result.saturated <= ctl_f.w_sat | (|qsat);
    end
  end

  // A zero divisor never reports a clamp.
  a_wzero_nosat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.w_zero |-> !result.saturated)
    else $error("w_zero result flagged saturated");

  // A zero divisor clears every coordinate.
  a_wzero_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.w_zero |->
      result.out_x == 0 && result.out_y == 0 && result.out_z == 0 && result.out_w == 0)
    else $error("w_zero result carries nonzero coordinates");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

endmodule

// ===== src/vtp_mac.sv =====
`timescale 1ns / 1ps
module vtp_mac
  import vtp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  meta_t                   meta_in,
  input  logic signed [31:0]      vx,
  input  logic signed [31:0]      vy,
  input  logic signed [31:0]      vz,
  input  matrix_t                 mat,
  output meta_t                   meta_out,
  output logic signed [SUM_W-1:0] sums [4]
);

  logic signed [31:0] vec [3];
  logic signed [63:0] prod [3][4];
  logic signed [31:0] row3 [4];
  meta_t              meta_b;

  assign vec[0] = vx;
  assign vec[1] = vy;
  assign vec[2] = vz;

  // Products stage: twelve 32x32 multiplies in parallel.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod[r][c] <= vec[r] * elem(mat, 2'(r), 2'(c));
      end
    end
    for (int c = 0; c < 4; c++) begin
      row3[c] <= elem(mat, 2'd3, 2'(c));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_b   <= '0;
      meta_out <= '0;
    end else begin
      meta_b   <= meta_in;
      meta_out <= meta_b;
    end
  end

  // Sum stage: add translation row only in point mode.
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      sums[c] <= SUM_W'(prod[0][c]) + SUM_W'(prod[1][c]) + SUM_W'(prod[2][c])
               + (meta_b.point ? (SUM_W'(row3[c]) <<< 16) : SUM_W'(0));
    end
  end

endmodule

// ===== src/vtp_div.sv =====
`timescale 1ns / 1ps
module vtp_div
  import vtp_pkg::*;
(
  input  logic             clk,
  input  logic [MAG_W-1:0] mag,
  input  logic [31:0]      wmag,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  logic [31:0]    rem   [DIV_LAT];
  logic [Q_W-1:0] dvd   [DIV_LAT];
  logic [Q_W-1:0] qs    [DIV_LAT];
  logic           ovfs  [DIV_LAT];
  logic [31:0]    dsr   [DIV_LAT];
  logic [32:0]    trial [Q_W];
  logic           ge    [Q_W];

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = {rem[k], dvd[k][Q_W-1]};
      ge[k]    = trial[k] >= {1'b0, dsr[k]};
    end
  end

  // Entry stage: range check on the high part, then one quotient bit per stage.
  always_ff @(posedge clk) begin
    ovfs[0] <= mag[MAG_W-1:Q_W] >= wmag;
    rem[0]  <= mag[MAG_W-1:Q_W];
    dvd[0]  <= mag[Q_W-1:0];
    qs[0]   <= '0;
    dsr[0]  <= wmag;
    for (int k = 0; k < Q_W; k++) begin
      rem[k+1]  <= ge[k] ? 32'(trial[k] - {1'b0, dsr[k]}) : trial[k][31:0];
      dvd[k+1]  <= dvd[k] << 1;
      qs[k+1]   <= {qs[k][Q_W-2:0], ge[k]};
      ovfs[k+1] <= ovfs[k];
      dsr[k+1]  <= dsr[k];
    end
  end

  assign quo = qs[DIV_LAT-1];
  assign ovf = ovfs[DIV_LAT-1];

endmodule
